// ===== hdl/gfedp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfedp_pkg
// Shared types, constants and the GF(2^8) multiply used by the dot-product
// cell chain.
// ----------------------------------------------------------------------------
package gfedp_pkg;

   localparam int unsigned MAX_SOURCES_DEFAULT = 8;
   localparam int unsigned BYTE_W              = 8;
   localparam int unsigned ROW_W               = 64;
   localparam int unsigned COUNT_W             = 4;
   localparam int unsigned CSR_INDEX_W         = 2;
   localparam int unsigned CSR_DATA_W          = 64;

   localparam logic [ROW_W-1:0]   ROW_RESET   = '0;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;
   localparam logic [BYTE_W-1:0]  POLY_RESET  = 8'h1d;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COEFFICIENT_ROW  = 2'd0,
      CSR_SOURCE_COUNT     = 2'd1,
      CSR_FIELD_POLYNOMIAL = 2'd2
   } csr_index_type;

   // word moving from one cell to the next
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] acc;
   } cell_link_type;

   // shift-and-xor product reduced modulo x^8 + poly
   function automatic logic [BYTE_W-1:0] gf_mul(
      input logic [BYTE_W-1:0] a_in,
      input logic [BYTE_W-1:0] b_in,
      input logic [BYTE_W-1:0] poly
   );
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] a;
      logic              top;
      acc = '0;
      a   = a_in;
      for (int bit_idx = 0; bit_idx < BYTE_W; bit_idx++) begin
         if (b_in[bit_idx]) begin
            acc = acc ^ a;
         end
         top = a[BYTE_W-1];
         a   = {a[BYTE_W-2:0], 1'b0};
         if (top) begin
            a = a ^ poly;
         end
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/gf256_erasure_dot_product_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gf256_erasure_dot_product_top
// GF(2^8) erasure-code dot product over up to eight source bytes.
//
// A word on req_ carries one byte from each source block at one byte
// position. rsp_coded_byte is the xor of the GF(2^8) products of each
// source byte with its coefficient from the configured row, over the first
// source_count sources (counts above MAX_SOURCES act as MAX_SOURCES).
// The datapath is a chain of MAX_SOURCES cells, one per source, each doing
// one multiply and xor and registering the word; rsp_valid comes from the
// last cell's register, so a word shows only after passing every cell, and
// one word is taken every cycle while the response side keeps up.
// When rsp_ready is low the last cell holds its word; earlier cells still
// advance into empty slots, so req_ready falls only once the chain is full.
// The csr_ port writes one of coefficient_row, source_count and
// field_polynomial, per csr_index; write it only while the chain is empty.
// Synchronous reset empties the chain and restores the register defaults
// (row 0, count 8, polynomial 0x1d).
// ----------------------------------------------------------------------------
module gf256_erasure_dot_product_top #(
   parameter int unsigned MAX_SOURCES = gfedp_pkg::MAX_SOURCES_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic [gfedp_pkg::BYTE_W-1:0]         req_source_byte_0,
   input  wire logic [gfedp_pkg::BYTE_W-1:0]         req_source_byte_1,
   input  wire logic [gfedp_pkg::BYTE_W-1:0]         req_source_byte_2,
   input  wire logic [gfedp_pkg::BYTE_W-1:0]         req_source_byte_3,
   input  wire logic [gfedp_pkg::BYTE_W-1:0]         req_source_byte_4,
   input  wire logic [gfedp_pkg::BYTE_W-1:0]         req_source_byte_5,
   input  wire logic [gfedp_pkg::BYTE_W-1:0]         req_source_byte_6,
   input  wire logic [gfedp_pkg::BYTE_W-1:0]         req_source_byte_7,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic [gfedp_pkg::BYTE_W-1:0]         rsp_coded_byte,
   input  wire logic                                 csr_write_enable,
   input  wire logic [gfedp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [gfedp_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int unsigned PORT_SOURCES = 8;

   logic [gfedp_pkg::ROW_W-1:0]                        row_ff;
   logic [gfedp_pkg::COUNT_W-1:0]                      count_ff;
   logic [gfedp_pkg::BYTE_W-1:0]                       poly_ff;
   logic [PORT_SOURCES-1:0][gfedp_pkg::BYTE_W-1:0]     src_all;
   gfedp_pkg::cell_link_type                           link   [MAX_SOURCES+1];
   logic [MAX_SOURCES-1:0][gfedp_pkg::BYTE_W-1:0]      bytes  [MAX_SOURCES+1];
   logic                                               ready  [MAX_SOURCES+1];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= gfedp_pkg::ROW_RESET;
         count_ff <= gfedp_pkg::COUNT_RESET;
         poly_ff  <= gfedp_pkg::POLY_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            gfedp_pkg::CSR_COEFFICIENT_ROW: begin
               row_ff <= csr_write_data[gfedp_pkg::ROW_W-1:0];
            end
            gfedp_pkg::CSR_SOURCE_COUNT: begin
               count_ff <= csr_write_data[gfedp_pkg::COUNT_W-1:0];
            end
            gfedp_pkg::CSR_FIELD_POLYNOMIAL: begin
               poly_ff <= csr_write_data[gfedp_pkg::BYTE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign src_all = {req_source_byte_7, req_source_byte_6, req_source_byte_5,
                     req_source_byte_4, req_source_byte_3, req_source_byte_2,
                     req_source_byte_1, req_source_byte_0};

   assign link[0]       = '{valid: req_valid, acc: '0};
   assign req_ready     = ready[0];
   assign ready[MAX_SOURCES] = rsp_ready;

   for (genvar g = 0; g < MAX_SOURCES; g++) begin : g_src
      assign bytes[0][g] = src_all[g];
   end

   for (genvar g = 0; g < MAX_SOURCES; g++) begin : g_cell
      gfedp_cell #(
         .MAX_SOURCES (MAX_SOURCES),
         .CELL_INDEX  (g)
      ) u_cell (
         .clock            (clock),
         .reset            (reset),
         .up_link          (link[g]),
         .up_bytes         (bytes[g]),
         .up_ready         (ready[g]),
         .coefficient      (row_ff[g*gfedp_pkg::BYTE_W +: gfedp_pkg::BYTE_W]),
         .field_polynomial (poly_ff),
         .source_count     (count_ff),
         .down_link        (link[g+1]),
         .down_bytes       (bytes[g+1]),
         .down_ready       (ready[g+1])
      );
   end

   assign rsp_valid      = link[MAX_SOURCES].valid;
   assign rsp_coded_byte = link[MAX_SOURCES].acc;

   // assertions
   a_ready_through : assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("chain not ready although response side is ready");

   a_first_cell_loads : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> link[1].valid)
      else $error("taken word missing from first cell");

   a_reset_empties : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_bubble_filled : assert property (@(posedge clock) disable iff (reset)
      !link[1].valid |-> req_ready)
      else $error("first cell empty but word refused");

endmodule
`default_nettype wire

// ===== hdl/gfedp_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gfedp_cell
// One cell of the chain: multiplies its own source byte by its coefficient,
// xors it into the sum if CELL_INDEX < source_count, and registers the word.
// ----------------------------------------------------------------------------
module gfedp_cell #(
   parameter int unsigned MAX_SOURCES = gfedp_pkg::MAX_SOURCES_DEFAULT,
   parameter int unsigned CELL_INDEX  = 0
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire gfedp_pkg::cell_link_type                 up_link,
   input  wire logic [MAX_SOURCES-1:0][gfedp_pkg::BYTE_W-1:0] up_bytes,
   output      logic                                     up_ready,
   input  wire logic [gfedp_pkg::BYTE_W-1:0]             coefficient,
   input  wire logic [gfedp_pkg::BYTE_W-1:0]             field_polynomial,
   input  wire logic [gfedp_pkg::COUNT_W-1:0]            source_count,
   output      gfedp_pkg::cell_link_type                 down_link,
   output      logic [MAX_SOURCES-1:0][gfedp_pkg::BYTE_W-1:0] down_bytes,
   input  wire logic                                     down_ready
);

   gfedp_pkg::cell_link_type                          link_ff;
   gfedp_pkg::cell_link_type                          link_in;
   logic [MAX_SOURCES-1:0][gfedp_pkg::BYTE_W-1:0]     bytes_ff;
   logic                                              active;
   logic [gfedp_pkg::BYTE_W-1:0]                      product;

   assign up_ready = !link_ff.valid || down_ready;
   assign active   = gfedp_pkg::COUNT_W'(CELL_INDEX) < source_count;

   always_comb begin
      product       = gfedp_pkg::gf_mul(up_bytes[CELL_INDEX], coefficient, field_polynomial);
      link_in.valid = up_link.valid;
      link_in.acc   = active ? (up_link.acc ^ product) : up_link.acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else if (up_ready) begin
         link_ff.valid <= link_in.valid;
      end
      if (up_ready) begin
         link_ff.acc <= link_in.acc;
         bytes_ff    <= up_bytes;
      end
   end

   assign down_link  = link_ff;
   assign down_bytes = bytes_ff;

endmodule
`default_nettype wire
